/* sv/qbcp_pkg.sv */
// Types, codes and capacity tables for the QR byte-mode codeword packer.
`timescale 1ns / 1ps

package qbcp_pkg;

  localparam int unsigned ROM_DEPTH = 40;

  // Command codes of an incoming word.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_PAD   = 2'd2
  } cmd_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_CODEWORD = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_TOO_LONG = 2'd2,
    KIND_SEQUENCE = 2'd3
  } kind_t;

  // Packing phase.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_FLUSH = 2'd2,
    PH_FILL  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] message_length;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] codeword;
    logic [5:0] symbol_version;
    logic       last_of_run;
  } out_word_t;

  localparam logic [3:0] MODE_NIBBLE        = 4'b0100;
  localparam logic [7:0] PAD_A              = 8'd236;
  localparam logic [7:0] PAD_B              = 8'd17;
  localparam logic [5:0] SHORT_COUNT_LAST_V = 6'd9;

  // Byte-mode capacity at level L, versions 1 to 40.
  localparam logic [11:0] CAP_ROM [ROM_DEPTH] = '{
    12'd17,   12'd32,   12'd53,   12'd78,   12'd106,  12'd134,  12'd154,  12'd192,
    12'd230,  12'd271,  12'd321,  12'd367,  12'd425,  12'd458,  12'd520,  12'd586,
    12'd644,  12'd718,  12'd792,  12'd858,  12'd929,  12'd1003, 12'd1091, 12'd1171,
    12'd1273, 12'd1367, 12'd1465, 12'd1528, 12'd1628, 12'd1732, 12'd1840, 12'd1952,
    12'd2068, 12'd2188, 12'd2303, 12'd2431, 12'd2563, 12'd2699, 12'd2809, 12'd2953
  };

  // Data codeword count at level L, versions 1 to 40.
  localparam logic [11:0] TOTAL_ROM [ROM_DEPTH] = '{
    12'd19,   12'd34,   12'd55,   12'd80,   12'd108,  12'd136,  12'd156,  12'd194,
    12'd232,  12'd274,  12'd324,  12'd370,  12'd428,  12'd461,  12'd523,  12'd589,
    12'd647,  12'd721,  12'd795,  12'd861,  12'd932,  12'd1006, 12'd1094, 12'd1174,
    12'd1276, 12'd1370, 12'd1468, 12'd1531, 12'd1631, 12'd1735, 12'd1843, 12'd1955,
    12'd2071, 12'd2191, 12'd2306, 12'd2434, 12'd2566, 12'd2702, 12'd2812, 12'd2956
  };

endpackage

/* sv/qbcp_word_if.sv */
// Valid/ready channel carrying one word of a chosen type.
`timescale 1ns / 1ps

interface qbcp_word_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/qr_byte_mode_codeword_packer_unit.sv */
// Top level of the QR byte-mode data codeword packer (level L).
`timescale 1ns / 1ps

//  channel | direction | word type           | contents
//  --------+-----------+---------------------+------------------------------------------
//  req     | in        | qbcp_pkg::in_word_t | command, message_length, data_byte
//  rsp     | out       | qbcp_pkg::out_word_t| kind, codeword, symbol_version, last_of_run
//
//  One input word is taken per cycle; most give one result word, a start that
//  picks version 10 or above gives two (mode/count header split over two words).
//  Results drain through a four-entry result queue; req.ready is high while the
//  queue has room for two words, so input keeps flowing while rsp is stalled
//  for up to two pending words, and only the queue depth throttles it.
//  Results are registered in the queue and appear on rsp in order.
//  rst (synchronous, active high) empties the queue, returns to idle with no
//  version chosen and primes the pad pattern to start on 236.

module qr_byte_mode_codeword_packer_unit #(
  parameter int unsigned VERSION_COUNT = 40
) (
  input  logic         clk,
  input  logic         rst,
  qbcp_word_if.sink    req,
  qbcp_word_if.source  rsp
);
  import qbcp_pkg::*;

  localparam int unsigned QDEPTH = 4;

  // Packing state
  logic [5:0]  version_reg;
  logic [3:0]  residue_nibble;
  logic [11:0] bytes_outstanding;
  logic [11:0] codewords_sent;
  phase_t      phase;
  logic        pad_toggle;
  logic [11:0] total_reg;       // data codeword count of the chosen version

  logic [5:0]  version_reg_next;
  logic [3:0]  residue_nibble_next;
  logic [11:0] bytes_outstanding_next;
  logic [11:0] codewords_sent_next;
  phase_t      phase_next;
  logic        pad_toggle_next;
  logic [11:0] total_reg_next;

  // Result queue
  out_word_t   qmem [QDEPTH];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  fill_count;

  in_word_t    w;
  logic        accept;
  logic        pop;
  out_word_t   res0;
  out_word_t   res1;
  logic        two_words;

  // Version search
  logic [5:0]  fit_ver;
  logic        fit_hit;
  logic [11:0] fit_total;

  assign w      = req.data;
  assign accept = req.valid && req.ready;
  assign pop    = rsp.valid && rsp.ready;

  assign req.ready = (fill_count <= 3'd2);
  assign rsp.valid = (fill_count != 3'd0);
  assign rsp.data  = qmem[rd_ptr];

  // Smallest version whose capacity holds the message; scan from the top so
  // the lowest match wins.
  always_comb begin
    fit_ver   = '0;
    fit_hit   = 1'b0;
    fit_total = '0;
    for (int i = VERSION_COUNT - 1; i >= 0; i--) begin
      if (CAP_ROM[i] >= w.message_length) begin
        fit_ver   = 6'(i + 1);
        fit_hit   = 1'b1;
        fit_total = TOTAL_ROM[i];
      end
    end
  end

  // Next state
  always_comb begin
    version_reg_next       = version_reg;
    residue_nibble_next    = residue_nibble;
    bytes_outstanding_next = bytes_outstanding;
    codewords_sent_next    = codewords_sent;
    phase_next             = phase;
    pad_toggle_next        = pad_toggle;
    total_reg_next         = total_reg;
    case (w.command)
      CMD_START: begin
        pad_toggle_next = 1'b1;
        if (!fit_hit) begin
          // Too long: drop the message and forget the version
          version_reg_next       = '0;
          residue_nibble_next    = '0;
          bytes_outstanding_next = '0;
          codewords_sent_next    = '0;
          phase_next             = PH_IDLE;
          total_reg_next         = '0;
        end else begin
          version_reg_next       = fit_ver;
          bytes_outstanding_next = w.message_length;
          residue_nibble_next    = w.message_length[3:0];
          total_reg_next         = fit_total;
          phase_next             = (w.message_length == '0) ? PH_FLUSH : PH_DATA;
          codewords_sent_next    = (fit_ver > SHORT_COUNT_LAST_V) ? 12'd2 : 12'd1;
        end
      end
      CMD_DATA: begin
        if (phase == PH_DATA) begin
          residue_nibble_next = w.data_byte[3:0];
          codewords_sent_next = codewords_sent + 12'd1;
          if (bytes_outstanding != '0) begin
            bytes_outstanding_next = bytes_outstanding - 12'd1;
          end
          if (bytes_outstanding <= 12'd1) begin
            phase_next = PH_FLUSH;
          end
        end
      end
      CMD_PAD: begin
        if (phase == PH_FLUSH) begin
          residue_nibble_next = '0;
          codewords_sent_next = codewords_sent + 12'd1;
          phase_next          = PH_FILL;
        end else if (phase == PH_FILL && codewords_sent < total_reg) begin
          pad_toggle_next     = ~pad_toggle;
          codewords_sent_next = codewords_sent + 12'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result words; symbol_version always reports the version after this word
  always_comb begin
    res0 = '{kind: KIND_SEQUENCE, codeword: 8'd0, symbol_version: version_reg_next,
             last_of_run: 1'b1};
    res1 = res0;
    two_words = 1'b0;
    case (w.command)
      CMD_START: begin
        if (!fit_hit) begin
          res0.kind = KIND_TOO_LONG;
        end else if (fit_ver > SHORT_COUNT_LAST_V) begin
          // 16-bit count, big-endian; its top nibble is always zero
          two_words        = 1'b1;
          res0.kind        = KIND_CODEWORD;
          res0.codeword    = {MODE_NIBBLE, 4'd0};
          res0.last_of_run = 1'b0;
          res1.kind        = KIND_CODEWORD;
          res1.codeword    = w.message_length[11:4];
        end else begin
          res0.kind     = KIND_CODEWORD;
          res0.codeword = {MODE_NIBBLE, w.message_length[7:4]};
        end
      end
      CMD_DATA: begin
        if (phase == PH_DATA) begin
          res0.kind     = KIND_CODEWORD;
          res0.codeword = {residue_nibble, w.data_byte[7:4]};
        end
      end
      CMD_PAD: begin
        if (phase == PH_FLUSH) begin
          res0.kind     = KIND_CODEWORD;
          res0.codeword = {residue_nibble, 4'd0};
        end else if (phase == PH_FILL) begin
          if (codewords_sent < total_reg) begin
            res0.kind     = KIND_CODEWORD;
            res0.codeword = pad_toggle ? PAD_A : PAD_B;
          end else begin
            res0.kind = KIND_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers; advance only on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      version_reg       <= '0;
      residue_nibble    <= '0;
      bytes_outstanding <= '0;
      codewords_sent    <= '0;
      phase             <= PH_IDLE;
      pad_toggle        <= 1'b1;
      total_reg         <= '0;
    end else if (accept) begin
      version_reg       <= version_reg_next;
      residue_nibble    <= residue_nibble_next;
      bytes_outstanding <= bytes_outstanding_next;
      codewords_sent    <= codewords_sent_next;
      phase             <= phase_next;
      pad_toggle        <= pad_toggle_next;
      total_reg         <= total_reg_next;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      qmem[wr_ptr] <= res0;
      if (two_words) begin
        qmem[wr_ptr + 2'd1] <= res1;
      end
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fill_count <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + (two_words ? 2'd2 : 2'd1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fill_count <= fill_count
                    + (accept ? (two_words ? 3'd2 : 3'd1) : 3'd0)
                    - (pop ? 3'd1 : 3'd0);
    end
  end

  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= 3'(QDEPTH))
    else $error("result queue overfilled");

  // A two-word start only when a long count is needed
  a_two_words_long: assert property (@(posedge clk) disable iff (rst)
    accept && two_words |=> version_reg > SHORT_COUNT_LAST_V && phase != PH_IDLE)
    else $error("two-word header without a long count");

  // Padding never runs past the version's codeword count
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FILL |-> codewords_sent <= total_reg)
    else $error("codeword count passed the version total");

endmodule

/* tb/tb_qr_byte_mode_codeword_packer_unit.sv */
// Self-checking testbench for the QR byte-mode codeword packer (level L).
`timescale 1ns / 1ps

module tb_qr_byte_mode_codeword_packer_unit;
  import qbcp_pkg::*;

  localparam int unsigned VERSION_COUNT = 40;
  localparam int unsigned RANDOM_ITEMS  = 900;
  // Tail of the random part that runs with no idling on either side.
  localparam int unsigned QUIET_TAIL    = 120;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;

  // One expectation pinned by hand to the first result of a directed word.
  typedef struct packed {
    bit        on;
    out_word_t w;
  } pin_t;

  // One row of the directed plan: a word, how often to send it, and an
  // optional hand-written first result.
  typedef struct {
    logic [1:0]  cmd;
    logic [11:0] len;
    logic [7:0]  data_byte;
    int          reps;
    bit          pinned;
    out_word_t   pin;
  } row_t;

  localparam out_word_t NOPIN = '0;

  logic clk;
  logic rst;

  qbcp_word_if #(.word_t(in_word_t))  req ();
  qbcp_word_if #(.word_t(out_word_t)) rsp ();

  qr_byte_mode_codeword_packer_unit #(
    .VERSION_COUNT(VERSION_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Packer state as the predictor sees it, after every accepted word.
  logic [5:0]  cur_version;
  logic [3:0]  residue;
  logic [11:0] bytes_left;
  logic [11:0] cw_count;
  phase_t      cur_phase;
  bit          pad_is_236;

  out_word_t   codeword_q [$];  // result words still to arrive, oldest first
  pin_t        pin_q [$];       // one entry per word handed to the request side
  int unsigned failures;
  int unsigned items_sent;
  int unsigned stall_left;
  bit          quiet;           // no idling on either side
  bit          send_calm;       // stretch with no sender gaps
  bit          sink_calm;       // stretch with no receiver stalls

  // Directed plan: error codes and extremes first, then an abandoned message,
  // a short message run to the end of its fill, the boundary between one- and
  // two-word headers, and the capacity edge of version 1.
  row_t plan [23] = '{
    // data, pad and the unused command straight after reset: out of sequence
    '{CMD_DATA,   12'd0,    8'h00, 1,  1'b1, '{KIND_SEQUENCE, 8'h00, 6'd0,  1'b1}},
    '{CMD_PAD,    12'd0,    8'h00, 1,  1'b1, '{KIND_SEQUENCE, 8'h00, 6'd0,  1'b1}},
    '{CMD_UNUSED, 12'd4095, 8'hFF, 1,  1'b1, '{KIND_SEQUENCE, 8'h00, 6'd0,  1'b1}},
    // longest length, and one past the largest capacity: too long
    '{CMD_START,  12'd4095, 8'h00, 1,  1'b1, '{KIND_TOO_LONG, 8'h00, 6'd0,  1'b1}},
    '{CMD_START,  12'd2954, 8'hFF, 1,  1'b1, '{KIND_TOO_LONG, 8'h00, 6'd0,  1'b1}},
    // exactly the largest capacity: version 40, two-word header
    '{CMD_START,  12'd2953, 8'h00, 1,  1'b1, '{KIND_CODEWORD, 8'h40, 6'd40, 1'b0}},
    '{CMD_DATA,   12'd0,    8'hFF, 1,  1'b0, NOPIN},
    // pad while bytes are still owed
    '{CMD_PAD,    12'd0,    8'h00, 1,  1'b1, '{KIND_SEQUENCE, 8'h00, 6'd40, 1'b1}},
    // empty message abandons the one in progress and goes straight to flush
    '{CMD_START,  12'd0,    8'h00, 1,  1'b1, '{KIND_CODEWORD, 8'h40, 6'd1,  1'b1}},
    '{CMD_DATA,   12'd0,    8'h00, 1,  1'b1, '{KIND_SEQUENCE, 8'h00, 6'd1,  1'b1}},
    '{CMD_PAD,    12'd0,    8'h00, 1,  1'b0, NOPIN},
    '{CMD_PAD,    12'd0,    8'h00, 17, 1'b0, NOPIN},
    // count reached: done, no codeword
    '{CMD_PAD,    12'd0,    8'h00, 1,  1'b1, '{KIND_DONE,     8'h00, 6'd1,  1'b1}},
    // last one-word header, then first two-word header
    '{CMD_START,  12'd230,  8'h00, 1,  1'b0, NOPIN},
    '{CMD_DATA,   12'd0,    8'h00, 1,  1'b0, NOPIN},
    '{CMD_START,  12'd231,  8'h00, 1,  1'b0, NOPIN},
    '{CMD_DATA,   12'd0,    8'hAA, 2,  1'b0, NOPIN},
    // capacity edge of version 1
    '{CMD_START,  12'd17,   8'h00, 1,  1'b0, NOPIN},
    '{CMD_START,  12'd18,   8'h00, 1,  1'b0, NOPIN},
    '{CMD_START,  12'd2,    8'h00, 1,  1'b0, NOPIN},
    '{CMD_DATA,   12'd0,    8'h5A, 2,  1'b0, NOPIN},
    '{CMD_PAD,    12'd0,    8'h00, 2,  1'b0, NOPIN},
    '{CMD_START,  12'd4095, 8'h00, 1,  1'b1, '{KIND_TOO_LONG, 8'h00, 6'd0,  1'b1}}
  };

  // Smallest version whose capacity holds len bytes, 0 when none does.
  function automatic logic [5:0] fit_version(input logic [11:0] len);
    for (int i = 0; i < VERSION_COUNT; i++) begin
      if (CAP_ROM[i] >= len) return 6'(i + 1);
    end
    return 6'd0;
  endfunction

  // Advance the predicted packer by one word and queue the result words it
  // yields. A pin, where set, stands in for the first of them.
  function automatic void predict_codewords(input in_word_t w, input pin_t pin);
    out_word_t   res [2];
    int          n;
    logic [5:0]  v;
    logic [7:0]  cw;
    logic [1:0]  kind;
    logic [11:0] total;
    n    = 1;
    kind = KIND_SEQUENCE;
    cw   = 8'h00;
    case (w.command)
      CMD_START: begin
        v = fit_version(w.message_length);
        if (v == 6'd0) begin
          // nothing fits: drop back to idle with no version
          cur_version = '0;
          residue     = '0;
          bytes_left  = '0;
          cw_count    = '0;
          cur_phase   = PH_IDLE;
          pad_is_236  = 1'b1;
          kind        = KIND_TOO_LONG;
        end else begin
          cur_version = v;
          bytes_left  = w.message_length;
          residue     = w.message_length[3:0];
          pad_is_236  = 1'b1;
          cur_phase   = (w.message_length == 12'd0) ? PH_FLUSH : PH_DATA;
          kind        = KIND_CODEWORD;
          if (v > SHORT_COUNT_LAST_V) begin
            // 16-bit count, big-endian: top nibble is always zero here
            cw_count = 12'd2;
            cw       = {MODE_NIBBLE, 4'h0};
            res[1]   = '{KIND_CODEWORD, w.message_length[11:4], v, 1'b1};
            n        = 2;
          end else begin
            cw_count = 12'd1;
            cw       = {MODE_NIBBLE, w.message_length[7:4]};
          end
        end
      end
      CMD_DATA: begin
        if (cur_phase == PH_DATA) begin
          cw      = {residue, w.data_byte[7:4]};
          residue = w.data_byte[3:0];
          if (bytes_left != 12'd0) bytes_left = bytes_left - 12'd1;
          cw_count = cw_count + 12'd1;
          if (bytes_left == 12'd0) cur_phase = PH_FLUSH;
          kind = KIND_CODEWORD;
        end
      end
      CMD_PAD: begin
        total = (cur_version == 6'd0) ? 12'd0 : TOTAL_ROM[cur_version - 6'd1];
        if (cur_phase == PH_FLUSH) begin
          cw        = {residue, 4'h0};
          residue   = '0;
          cw_count  = cw_count + 12'd1;
          cur_phase = PH_FILL;
          kind      = KIND_CODEWORD;
        end else if (cur_phase == PH_FILL) begin
          if (cw_count < total) begin
            cw         = pad_is_236 ? PAD_A : PAD_B;
            pad_is_236 = !pad_is_236;
            cw_count   = cw_count + 12'd1;
            kind       = KIND_CODEWORD;
          end else begin
            kind = KIND_DONE;
          end
        end
      end
      default: ;
    endcase
    res[0] = '{kind, cw, cur_version, (n == 1)};
    if (pin.on) res[0] = pin.w;
    for (int i = 0; i < n; i++) codeword_q.push_back(res[i]);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  // Hand one word to the request side and hold it until accepted. Entered and
  // left at a falling edge; an idle burst, if any, goes in front of the word.
  task automatic send_word(input logic [1:0] cmd, input logic [11:0] len,
                           input logic [7:0] dbyte, input bit pinned,
                           input out_word_t pin);
    in_word_t w;
    w.command        = cmd;
    w.message_length = len;
    w.data_byte      = dbyte;
    if (!quiet && !send_calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    pin_q.push_back('{pinned, pin});
    req.valid <= 1'b1;
    req.data  <= w;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    items_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up well past the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: stall in random bursts; no new burst starts during the quiet tail.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      rsp.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet && !sink_calm && $urandom_range(0, 4) == 0) begin
      rsp.ready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Check each result word against the oldest expectation, then predict for
  // the request word taken at the same edge. Results are registered in the queue
  // before they show on rsp, so the order within the edge cannot matter.
  always @(posedge clk) begin : watch
    out_word_t want;
    pin_t      pin;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (codeword_q.size() == 0) begin
          $error("result word with nothing expected: kind %0d, codeword %0d",
                 rsp.data.kind, rsp.data.codeword);
          failures++;
        end else begin
          want = codeword_q.pop_front();
          check_field("kind", want.kind, rsp.data.kind);
          check_field("codeword", want.codeword, rsp.data.codeword);
          check_field("symbol_version", want.symbol_version, rsp.data.symbol_version);
          check_field("last_of_run", want.last_of_run, rsp.data.last_of_run);
        end
      end
      if (req.valid && req.ready) begin
        pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
        predict_codewords(req.data, pin);
      end
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned len;
    int unsigned nbytes;
    int          npads;
    int          hdr;
    bit          full;
    logic [5:0]  v;

    // Drive every input to a known value from time zero.
    rst        = 1'b1;
    req.valid  = 1'b0;
    req.data   = '0;
    rsp.ready  = 1'b0;
    stall_left = 0;
    failures   = 0;
    items_sent = 0;
    quiet      = 1'b0;
    send_calm  = 1'b0;
    sink_calm  = 1'b0;

    cur_version = '0;
    residue     = '0;
    bytes_left  = '0;
    cw_count    = '0;
    cur_phase   = PH_IDLE;
    pad_is_236  = 1'b1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed plan.
    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        send_word(plan[i].cmd, plan[i].len, plan[i].data_byte, plan[i].pinned,
                  plan[i].pin);
      end
    end

    // Random part: mostly well-formed messages with random content. Short
    // messages run through flush and fill to done; longer ones are cut short
    // by the next start, since filling a large version would take thousands
    // of words. The rest is noise of any command.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      quiet     = (items_sent + QUIET_TAIL >= RANDOM_ITEMS);
      send_calm = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                    8'($urandom_range(0, 255)), 1'b0, NOPIN);
        end
      end else begin
        full = (r < 72);
        if (full)        len = $urandom_range(0, 32);
        else if (r < 86) len = $urandom_range(33, 400);
        else if (r < 95) len = $urandom_range(401, 2953);
        else             len = $urandom_range(2954, 4095);
        v = fit_version(12'(len));
        send_word(CMD_START, 12'(len), 8'($urandom_range(0, 255)), 1'b0, NOPIN);
        if (v != 6'd0) begin
          nbytes = full ? len : $urandom_range(0, 12);
          for (int k = 0; k < nbytes; k++) begin
            // now and then slip in a pad or an unused command mid-message
            if ($urandom_range(0, 19) == 0) begin
              send_word(($urandom_range(0, 1) == 0) ? CMD_PAD : CMD_UNUSED,
                        12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                        1'b0, NOPIN);
            end
            send_word(CMD_DATA, 12'($urandom_range(0, 4095)),
                      8'($urandom_range(0, 255)), 1'b0, NOPIN);
          end
          if (full) begin
            // flush, fill to the version's count, then up to two done ticks
            hdr   = (v > SHORT_COUNT_LAST_V) ? 2 : 1;
            npads = int'(TOTAL_ROM[v - 6'd1]) - hdr - int'(len) + $urandom_range(0, 2);
            for (int k = 0; k < npads; k++) begin
              if ($urandom_range(0, 19) == 0) begin
                send_word(CMD_DATA, 12'($urandom_range(0, 4095)),
                          8'($urandom_range(0, 255)), 1'b0, NOPIN);
              end
              send_word(CMD_PAD, 12'($urandom_range(0, 4095)),
                        8'($urandom_range(0, 255)), 1'b0, NOPIN);
            end
          end else if ($urandom_range(0, 1) == 0) begin
            // early pad: out of sequence while bytes are owed
            send_word(CMD_PAD, 12'($urandom_range(0, 4095)),
                      8'($urandom_range(0, 255)), 1'b0, NOPIN);
          end
        end
      end
    end

    // Drop valid, drain every expected word, then give anything stray time to show up.
    req.valid <= 1'b0;
    while (codeword_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
